### hw/rtl/fdss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared types and constants of the frame delay slot selector.
// ----------------------------------------------------------------------------
package fdss_pkg;

  // Default number of ring slots.
  localparam int FDSS_SLOTS = 32;

  // Width of one timestamp and of the delay register.
  localparam int FDSS_STAMP_W = 32;

  // Width of the slot numbers carried in a result word.
  localparam int FDSS_SLOT_W = 5;

  // Delay register value after reset, in microsecond ticks.
  localparam logic [FDSS_STAMP_W-1:0] FDSS_DELAY_RESET = 32'd500000;

  // Result word: write slot, read slot and hit flag, padded to two bytes.
  localparam int FDSS_RES_BITS = 2 * FDSS_SLOT_W + 1;
  localparam int FDSS_RES_W    = ((FDSS_RES_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    FDSS_IDLE,
    FDSS_WALK,
    FDSS_DONE
  } fdss_state_e;

  typedef struct packed {
    logic [FDSS_SLOT_W-1:0] write_slot;
    logic [FDSS_SLOT_W-1:0] read_slot;
    logic                   hit;
  } fdss_res_t;

endpackage

### hw/rtl/fdss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fdss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/fdss_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdss_walker
// Stores each timestamp in the ring and walks the ring for the read slot.
// ----------------------------------------------------------------------------
module fdss_walker
  import fdss_pkg::*;
#(
  parameter int SLOTS = FDSS_SLOTS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [FDSS_STAMP_W-1:0] delay_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [FDSS_STAMP_W-1:0] now_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output fdss_res_t               res_o
);

  localparam int PW = $clog2(SLOTS);
  localparam logic [PW-1:0] LAST_SLOT = PW'(SLOTS - 1);
  localparam logic [PW:0]   SLOT_COUNT = (PW + 1)'(SLOTS);

  fdss_state_e state_q, state_d;

  logic [PW-1:0]           wp_q, wp_d;
  logic [PW-1:0]           rp_q, rp_d;
  logic                    hit_q, hit_d;
  logic [FDSS_STAMP_W-1:0] now_q, now_d;
  logic [SLOTS-1:0]        valid_q, valid_d;
  logic [PW-1:0]           raddr_q, raddr_d;
  logic [PW:0]             issued_q, issued_d;
  logic                    pend_q, pend_d;
  logic [PW-1:0]           paddr_q, paddr_d;
  logic                    have_prev_q, have_prev_d;
  logic                    prev_old_q, prev_old_d;
  logic [PW-1:0]           prev_addr_q, prev_addr_d;

  logic                    accept;
  logic                    ram_re;
  logic [FDSS_STAMP_W-1:0] ram_rdata;
  logic [FDSS_STAMP_W-1:0] stamp;
  logic [FDSS_STAMP_W:0]   age;
  logic                    younger;
  logic [PW+FDSS_SLOT_W-1:0] wp_ext;
  logic [PW+FDSS_SLOT_W-1:0] rp_ext;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign accept = in_valid_i && in_ready_o;

  fdss_ram #(
    .WIDTH (FDSS_STAMP_W),
    .DEPTH (SLOTS)
  ) u_stamps (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (now_i),
    .re_i    (ram_re),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  // A slot never written since reset holds a zero stamp.
  assign stamp   = valid_q[paddr_q] ? ram_rdata : '0;
  // Signed 33-bit age; a stamp later than now counts as younger.
  assign age     = {1'b0, now_q} - {1'b0, stamp};
  assign younger = age[FDSS_STAMP_W] || (age[FDSS_STAMP_W-1:0] < delay_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FDSS_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      hit_q       <= 1'b0;
      valid_q     <= '0;
      issued_q    <= '0;
      pend_q      <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      hit_q       <= hit_d;
      valid_q     <= valid_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    raddr_q     <= raddr_d;
    paddr_q     <= paddr_d;
    prev_old_q  <= prev_old_d;
    prev_addr_q <= prev_addr_d;
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    hit_d       = hit_q;
    now_d       = now_q;
    valid_d     = valid_q;
    raddr_d     = raddr_q;
    issued_d    = issued_q;
    pend_d      = 1'b0;
    paddr_d     = paddr_q;
    have_prev_d = have_prev_q;
    prev_old_d  = prev_old_q;
    prev_addr_d = prev_addr_q;
    ram_re      = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      FDSS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          now_d         = now_i;
          valid_d[wp_q] = 1'b1;
          if (delay_i == '0) begin
            rp_d    = wp_q;
            hit_d   = 1'b1;
            state_d = FDSS_DONE;
          end else begin
            raddr_d     = next_slot(rp_q);
            issued_d    = '0;
            have_prev_d = 1'b0;
            hit_d       = 1'b0;
            state_d     = FDSS_WALK;
          end
        end
      end

      FDSS_WALK: begin
        // Read one slot per cycle, from one past the read pointer round to it.
        if (issued_q != SLOT_COUNT) begin
          ram_re   = 1'b1;
          pend_d   = 1'b1;
          paddr_d  = raddr_q;
          raddr_d  = next_slot(raddr_q);
          issued_d = issued_q + 1'b1;
        end
        if (pend_q) begin
          if (have_prev_q && prev_old_q && younger) begin
            rp_d    = prev_addr_q;
            hit_d   = 1'b1;
            pend_d  = 1'b0;
            state_d = FDSS_DONE;
          end else begin
            have_prev_d = 1'b1;
            prev_old_d  = !younger;
            prev_addr_d = paddr_q;
          end
        end else if (issued_q == SLOT_COUNT) begin
          state_d = FDSS_DONE;
        end
      end

      FDSS_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          wp_d    = next_slot(wp_q);
          state_d = FDSS_IDLE;
        end
      end

      default: begin
        state_d = FDSS_IDLE;
      end
    endcase
  end

  assign wp_ext = {{FDSS_SLOT_W{1'b0}}, wp_q};
  assign rp_ext = {{FDSS_SLOT_W{1'b0}}, rp_q};

  assign res_o.write_slot = wp_ext[FDSS_SLOT_W-1:0];
  assign res_o.read_slot  = rp_ext[FDSS_SLOT_W-1:0];
  assign res_o.hit        = hit_q;

endmodule

### hw/rtl/frame_delay_slot_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_delay_slot_selector
// Stores frame timestamps in a ring and picks the slot to display after a
// programmable delay.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word content (lowest bit first)
//  -------   ---------  ---------------------------------------------------
//  s_axis    in         now_time[31:0]
//  m_axis    out        write_slot[4:0], read_slot[9:5], search_hit[10], pad
//  cfg       in         delay_ticks[31:0]
//
// With a zero delay the walker goes from its idle state straight to its
// done state and offers the result to the output register. Otherwise the
// walker reads the timestamp RAM one slot per cycle through its single read
// port. Reset clears the pointers and the per-slot valid bits, so the RAM
// itself needs no clearing pass. A new word is accepted while a result still
// waits in the output register; the walker stalls at its end only when that
// register is still full.
//
module frame_delay_slot_selector
  import fdss_pkg::*;
#(
  parameter int SLOTS = FDSS_SLOTS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input frame words.
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [FDSS_STAMP_W-1:0] s_axis_tdata_i,  // now_time[31:0]
  // Result words.
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  // write_slot[4:0], read_slot[9:5], search_hit[10], zero padding [15:11]
  output logic [FDSS_RES_W-1:0]   m_axis_tdata_o,
  // Delay register write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [FDSS_STAMP_W-1:0] cfg_data_i       // delay_ticks[31:0]
);

  logic [FDSS_STAMP_W-1:0] delay_q;
  logic                    out_valid_q;
  fdss_res_t               out_res_q;
  logic                    res_valid;
  logic                    res_ready;
  fdss_res_t               res;

  // The delay register takes a write in any cycle; writes are meant to come
  // only while no word is in flight.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= FDSS_DELAY_RESET;
    end else if (cfg_valid_i) begin
      delay_q <= cfg_data_i;
    end
  end

  fdss_walker #(
    .SLOTS (SLOTS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .delay_i     (delay_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .now_i       (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The output register takes a new result once its previous one has gone.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(FDSS_RES_W - FDSS_RES_BITS){1'b0}}, out_res_q.hit,
                            out_res_q.read_slot, out_res_q.write_slot};

endmodule
